### rtl/frame_receive_checker_assert.svh
// Assertion macros for the frame receive checker.
// Depends on nothing; modules that assert include this file by name.
`ifndef FRAME_RECEIVE_CHECKER_ASSERT_SVH
`define FRAME_RECEIVE_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, muted while reset is asserted.
`define FRC_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("frame_receive_checker: assertion failed");
// Clocked check that also holds through reset.
`define FRC_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("frame_receive_checker: assertion failed");
`else
`define FRC_ASSERT(lbl, clk_s, rstn_s, prop)
`define FRC_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

### rtl/frc_pkg.sv
// Shared types and constants of the frame receive checker.
// No dependencies.
`timescale 1ns / 1ps

package frc_pkg;

  localparam logic [7:0] TERMINATOR     = 8'hFF;
  localparam logic [3:0] NIBBLE_MASK    = 4'hF;
  localparam int         FRAME_OVERHEAD = 3;

  localparam int          CNT_W     = 9;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // config register indexes
  localparam int          CFG_IDX_W       = 2;
  localparam int          CFG_DATA_W      = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEANING_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_MASK  = 2'd2;

  localparam logic [7:0]  MAX_PAYLOAD_RST   = 8'd250;
  localparam logic [4:0]  MEANING_COUNT_RST = 5'd16;
  localparam logic [15:0] HANDLER_MASK_RST  = 16'h0000;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // verdict status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_OVER_LENGTH = 3'd1;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
  localparam logic [2:0] ST_BAD_TERM    = 3'd3;
  localparam logic [2:0] ST_BAD_MEANING = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [7:0] frame_length;
    logic [3:0] meaning_code;
    logic [3:0] type_code;
    logic       delivered;
  } out_t;

endpackage

### rtl/frame_receive_checker.sv
// Frame receive checker: per-byte frame check, payload pass-through, verdict.
// Depends on frc_pkg and frame_receive_checker_assert.svh.
`timescale 1ns / 1ps
// Output: each result is registered, by way of the skid entry while the output stalls, and drives out_valid from there.
// Throughput: one byte per cycle; the two-entry output (register plus skid)
// keeps in_ready high unless two results are waiting on the output side.
// Reset: synchronous, active low; clears frame state, config to defaults
// (max_payload 250, meaning_count 16, handler_mask 0) and output valids.
// cfg_ready is always high; a write lands at the clock edge of its handshake.

`include "frame_receive_checker_assert.svh"

module frame_receive_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // byte input
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  frc_pkg::in_t                           in_data,
  // result output
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output frc_pkg::out_t                          out_data,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [frc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [frc_pkg::CFG_DATA_W-1:0]         cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  max_payload_r;
  logic [4:0]  meaning_count_r;
  logic [15:0] handler_mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r   <= frc_pkg::MAX_PAYLOAD_RST;
      meaning_count_r <= frc_pkg::MEANING_COUNT_RST;
      handler_mask_r  <= frc_pkg::HANDLER_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        frc_pkg::CFG_MAX_PAYLOAD:   max_payload_r   <= cfg_data[7:0];
        frc_pkg::CFG_MEANING_COUNT: meaning_count_r <= cfg_data[4:0];
        frc_pkg::CFG_HANDLER_MASK:  handler_mask_r  <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state: position in chunk, header and length bytes
  // ---------------------------------------------------------------------------
  logic [frc_pkg::CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]                header_r, header_nxt;
  logic [7:0]                length_r, length_nxt;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Per-byte decision (one pass of short logic)
  // ---------------------------------------------------------------------------
  logic                      res_valid;
  frc_pkg::out_t             res;
  logic [7:0]                hdr_eff;
  logic [7:0]                len_eff;
  logic [3:0]                meaning;
  logic [frc_pkg::CNT_W:0]   total;
  logic [frc_pkg::CNT_W:0]   expect_total;
  logic [frc_pkg::CNT_W-1:0] pay_idx;
  logic [2:0]                status;

  always_comb begin
    hdr_eff = (byte_count_r == '0) ? in_data.rx_byte : header_r;
    if (byte_count_r == '0) begin
      len_eff = 8'd0;
    end else if (byte_count_r == frc_pkg::CNT_W'(1)) begin
      len_eff = in_data.rx_byte;
    end else begin
      len_eff = length_r;
    end
    meaning      = hdr_eff[7:4];
    total        = {1'b0, byte_count_r} + (frc_pkg::CNT_W+1)'(1);
    expect_total = (frc_pkg::CNT_W+1)'(len_eff)
                 + (frc_pkg::CNT_W+1)'(frc_pkg::FRAME_OVERHEAD);
    pay_idx      = byte_count_r - frc_pkg::CNT_W'(2);

    // checks in priority order; a one-byte chunk is a mismatch
    priority if (total < (frc_pkg::CNT_W+1)'(2)) begin
      status = frc_pkg::ST_LEN_MISMATCH;
    end else if (len_eff > max_payload_r) begin
      status = frc_pkg::ST_OVER_LENGTH;
    end else if (total != expect_total) begin
      status = frc_pkg::ST_LEN_MISMATCH;
    end else if (in_data.rx_byte != frc_pkg::TERMINATOR) begin
      status = frc_pkg::ST_BAD_TERM;
    end else if ({1'b0, meaning} >= meaning_count_r) begin
      status = frc_pkg::ST_BAD_MEANING;
    end else begin
      status = frc_pkg::ST_OK;
    end

    res            = '0;
    res_valid      = 1'b0;
    byte_count_nxt = byte_count_r;
    header_nxt     = header_r;
    length_nxt     = length_r;

    if (in_data.chunk_end) begin
      res_valid        = 1'b1;
      res.kind         = frc_pkg::KIND_VERDICT;
      res.status       = status;
      res.frame_length = len_eff;
      res.meaning_code = meaning;
      res.type_code    = hdr_eff[3:0] & frc_pkg::NIBBLE_MASK;
      res.delivered    = (status == frc_pkg::ST_OK) && handler_mask_r[meaning];
      byte_count_nxt   = '0;
      header_nxt       = 8'd0;
      length_nxt       = 8'd0;
    end else begin
      if (byte_count_r == '0) begin
        header_nxt = in_data.rx_byte;
      end else if (byte_count_r == frc_pkg::CNT_W'(1)) begin
        length_nxt = in_data.rx_byte;
      end else if ((length_r <= max_payload_r) &&
                   (pay_idx < frc_pkg::CNT_W'(length_r))) begin
        res_valid        = 1'b1;
        res.kind         = frc_pkg::KIND_PAYLOAD;
        res.payload_byte = in_data.rx_byte;
      end
      // long chunks saturate and end as a mismatch, or as over-length if the length byte exceeds max_payload
      if (byte_count_r != frc_pkg::COUNT_MAX) begin
        byte_count_nxt = byte_count_r + frc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      header_r     <= 8'd0;
      length_r     <= 8'd0;
    end else if (in_acc) begin
      byte_count_r <= byte_count_nxt;
      header_r     <= header_nxt;
      length_r     <= length_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid entry
  // ---------------------------------------------------------------------------
  logic          out_valid_r, skid_valid_r;
  frc_pkg::out_t out_data_r, skid_data_r;
  logic          out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_acc && res_valid;
      end
    end else if (in_acc && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc && res_valid) begin
        out_data_r <= res;
      end
    end else if (in_acc && res_valid) begin
      skid_data_r <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FRC_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `FRC_ASSERT(a_verdict_clears, clk, rst_n,
              (in_acc && in_data.chunk_end) |=> (byte_count_r == '0))
  `FRC_ASSERT(a_count_steps, clk, rst_n,
              (in_acc && !in_data.chunk_end && byte_count_r != frc_pkg::COUNT_MAX)
              |=> (byte_count_r == $past(byte_count_r) + frc_pkg::CNT_W'(1)))
  `FRC_ASSERT(a_delivered_ok, clk, rst_n,
              (out_valid_r && out_data_r.delivered)
              |-> (out_data_r.status == frc_pkg::ST_OK &&
                   out_data_r.kind == frc_pkg::KIND_VERDICT))
  `FRC_ASSERT_ALWAYS(a_reset_empty, clk,
                     !rst_n |=> (!out_valid_r && !skid_valid_r))

endmodule
